// ===== hdl/rvalu_pkg.sv =====
package rvalu_pkg;

   localparam int XLen        = 32;
   localparam int RegCount    = 32;
   localparam int RegIdxWidth = $clog2(RegCount);

   localparam logic [5:0] RegLimit = 6'(RegCount);

   localparam logic [6:0] OpcImm     = 7'h13;
   localparam logic [6:0] OpcReg     = 7'h33;
   localparam logic [6:0] Funct7Zero = 7'h00;
   localparam logic [6:0] Funct7Alt  = 7'h20;

   typedef enum logic [1:0] {
      StatusOk        = 2'd0,
      StatusIllegal   = 2'd1,
      StatusUnhandled = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      F3AddSub = 3'd0,
      F3Sll    = 3'd1,
      F3Slt    = 3'd2,
      F3Sltu   = 3'd3,
      F3Xor    = 3'd4,
      F3Shr    = 3'd5,
      F3Or     = 3'd6,
      F3And    = 3'd7
   } funct3_type;

endpackage

// ===== hdl/rv32i_integer_alu_execute_unit.sv =====
// An accepted instruction is held in stage 1, and its result in the response register.
// Throughput: one instruction per cycle unless the response stalls; the register file is
// read on accept, written when the result is registered, and forwarded to the next one.
// Reset (synchronous, active high) clears the pipeline and marks every register file
// entry as unwritten, so that all registers read as zero until they are written.
module rv32i_integer_alu_execute_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instruction,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic        rsp_write_enable,
   output logic [4:0]  rsp_dest_index,
   output logic [31:0] rsp_write_value
);
   import rvalu_pkg::*;

   logic [XLen-1:0] regfile_mem [RegCount];
   logic [RegCount-1:0] vld_ff, vld_in;

   logic            s1_valid_ff, s1_valid_in;
   logic [31:0]     s1_instr_ff;
   logic [XLen-1:0] s1_a_mem_ff, s1_b_mem_ff;
   logic            s1_a_vld_ff, s1_b_vld_ff;
   logic            s1_a_hit_ff, s1_b_hit_ff;
   logic [XLen-1:0] fwd_data_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff;
   logic            rsp_we_ff;
   logic [4:0]      rsp_rd_ff;
   logic [XLen-1:0] rsp_value_ff;

   logic            accept;
   logic            s1_advance;
   logic            s1_move;
   logic [4:0]      req_rs1, req_rs2;
   logic            rs1_in_range, rs2_in_range;
   logic            wr_en;

   logic [6:0]      opc;
   logic [4:0]      rd;
   funct3_type      f3;
   logic [6:0]      f7;
   logic            is_reg;
   logic [XLen-1:0] op_a, op_b;
   logic [4:0]      shamt;
   logic [XLen-1:0] result;
   status_type      status;

   assign req_rs1      = req_instruction[19:15];
   assign req_rs2      = req_instruction[24:20];
   assign rs1_in_range = {1'b0, req_rs1} < RegLimit;
   assign rs2_in_range = {1'b0, req_rs2} < RegLimit;

   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign s1_move    = s1_valid_ff && s1_advance;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;

   assign opc    = s1_instr_ff[6:0];
   assign rd     = s1_instr_ff[11:7];
   assign f3     = funct3_type'(s1_instr_ff[14:12]);
   assign f7     = s1_instr_ff[31:25];
   assign is_reg = (opc == OpcReg);

   assign op_a = s1_a_hit_ff ? fwd_data_ff : (s1_a_vld_ff ? s1_a_mem_ff : '0);

   always_comb begin
      logic [XLen-1:0] rs2_val;
      rs2_val = s1_b_hit_ff ? fwd_data_ff : (s1_b_vld_ff ? s1_b_mem_ff : '0);
      if (is_reg) begin
         op_b  = rs2_val;
         shamt = rs2_val[4:0];
      end else begin
         op_b  = {{(XLen-12){s1_instr_ff[31]}}, s1_instr_ff[31:20]};
         shamt = s1_instr_ff[24:20];
      end
   end

   always_comb begin
      result = '0;
      status = StatusOk;
      if (opc == OpcImm || opc == OpcReg) begin
         case (f3)
            F3AddSub: begin
               if (is_reg && f7 == Funct7Alt) begin
                  result = op_a - op_b;
               end else if (is_reg && f7 != Funct7Zero) begin
                  status = StatusIllegal;
               end else begin
                  result = op_a + op_b;
               end
            end
            F3Sll: begin
               if (f7 != Funct7Zero) begin
                  status = StatusIllegal;
               end else begin
                  result = op_a << shamt;
               end
            end
            F3Shr: begin
               if (f7 == Funct7Zero) begin
                  result = op_a >> shamt;
               end else if (f7 == Funct7Alt) begin
                  result = XLen'($signed(op_a) >>> shamt);
               end else begin
                  status = StatusIllegal;
               end
            end
            default: begin
               if (is_reg && f7 != Funct7Zero) begin
                  status = StatusIllegal;
               end else begin
                  case (f3)
                     F3Slt:   result = {{(XLen-1){1'b0}}, $signed(op_a) < $signed(op_b)};
                     F3Sltu:  result = {{(XLen-1){1'b0}}, op_a < op_b};
                     F3Xor:   result = op_a ^ op_b;
                     F3Or:    result = op_a | op_b;
                     default: result = op_a & op_b;
                  endcase
               end
            end
         endcase
         if (status != StatusOk) begin
            result = '0;
         end
      end else begin
         status = StatusUnhandled;
      end
   end

   assign wr_en = s1_move && status == StatusOk && rd != 5'd0 && {1'b0, rd} < RegLimit;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[rd[RegIdxWidth-1:0]] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         regfile_mem[rd[RegIdxWidth-1:0]] <= result;
      end
   end

   // A write in the same cycle as the read is not yet visible in the memory, so the
   // value is taken from the forwarding register instead.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instruction;
         s1_a_mem_ff <= regfile_mem[req_rs1[RegIdxWidth-1:0]];
         s1_b_mem_ff <= regfile_mem[req_rs2[RegIdxWidth-1:0]];
         s1_a_vld_ff <= rs1_in_range && vld_ff[req_rs1[RegIdxWidth-1:0]];
         s1_b_vld_ff <= rs2_in_range && vld_ff[req_rs2[RegIdxWidth-1:0]];
         s1_a_hit_ff <= wr_en && rd == req_rs1;
         s1_b_hit_ff <= wr_en && rd == req_rs2;
      end
      if (wr_en) begin
         fwd_data_ff <= result;
      end
      if (s1_move) begin
         rsp_status_ff <= status;
         rsp_we_ff     <= wr_en;
         rsp_rd_ff     <= rd;
         rsp_value_ff  <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_write_enable = rsp_we_ff;
   assign rsp_dest_index   = rsp_rd_ff;
   assign rsp_write_value  = rsp_value_ff;

`ifndef SYNTHESIS
   a_we_only_when_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_enable |-> rsp_status == StatusOk && rsp_dest_index != 5'd0)
      else $error("register write reported for a failed or x0 instruction");

   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != StatusOk |-> rsp_write_value == '0)
      else $error("non-zero result reported for an instruction that failed");

   a_x0_never_written: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0])
      else $error("register x0 has been written");

   a_reset_clears_valid: assert property (@(posedge clock)
      $past(reset) |-> vld_ff == '0 && !s1_valid_ff && !rsp_valid_ff)
      else $error("state not cleared after reset");

   a_write_needs_transfer: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> s1_valid_ff && (!rsp_valid_ff || rsp_ready))
      else $error("register file written without a result transfer");
`endif

endmodule

// ===== tb/alu_result_checker.sv =====
`timescale 1ns / 100ps

module alu_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_instruction,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic        rsp_write_enable,
   input  logic [4:0]  rsp_dest_index,
   input  logic [31:0] rsp_write_value,
   output int          mismatch_count,
   output int          pending_count
);
   import rvalu_pkg::*;

   typedef struct packed {
      status_type  status;
      logic        write_enable;
      logic [4:0]  dest_index;
      logic [31:0] write_value;
   } retire_info_type;

   logic [XLen-1:0] shadow_regs [RegCount];
   retire_info_type pending_results [$];

   function automatic logic [XLen-1:0] read_shadow(logic [4:0] idx);
      if (idx == 5'd0 || 6'(idx) >= RegLimit) return '0;
      return shadow_regs[idx];
   endfunction

   function automatic retire_info_type predict_retire(logic [31:0] word);
      retire_info_type info;
      logic [6:0]      opcode;
      logic [6:0]      f7;
      funct3_type      f3;
      logic [4:0]      rd;
      logic [4:0]      amount;
      logic            is_reg;
      logic [XLen-1:0] a;
      logic [XLen-1:0] b;
      logic [XLen-1:0] r;
      status_type      st;
      opcode = word[6:0];
      rd     = word[11:7];
      f3     = funct3_type'(word[14:12]);
      f7     = word[31:25];
      info.dest_index   = rd;
      info.write_enable = 1'b0;
      info.write_value  = '0;
      if (opcode != OpcImm && opcode != OpcReg) begin
         info.status = StatusUnhandled;
         return info;
      end
      is_reg = (opcode == OpcReg);
      a      = read_shadow(word[19:15]);
      b      = is_reg ? read_shadow(word[24:20]) : {{20{word[31]}}, word[31:20]};
      amount = is_reg ? b[4:0] : word[24:20];
      st     = StatusOk;
      r      = '0;
      case (f3)
         F3AddSub: begin
            if (is_reg && f7 == Funct7Alt) r = a - b;
            else if (is_reg && f7 != Funct7Zero) st = StatusIllegal;
            else r = a + b;
         end
         F3Sll: begin
            if (f7 != Funct7Zero) st = StatusIllegal;
            else r = a << amount;
         end
         F3Shr: begin
            if (f7 == Funct7Zero) r = a >> amount;
            else if (f7 == Funct7Alt) r = $signed(a) >>> amount;
            else st = StatusIllegal;
         end
         default: begin
            if (is_reg && f7 != Funct7Zero) begin
               st = StatusIllegal;
            end else begin
               case (f3)
                  F3Slt:   r = {31'd0, $signed(a) < $signed(b)};
                  F3Sltu:  r = {31'd0, a < b};
                  F3Xor:   r = a ^ b;
                  F3Or:    r = a | b;
                  default: r = a & b;
               endcase
            end
         end
      endcase
      info.status = st;
      if (st == StatusOk) begin
         info.write_value  = r;
         info.write_enable = (rd != 5'd0) && (6'(rd) < RegLimit);
      end
      return info;
   endfunction

   always @(posedge clock) begin
      retire_info_type exp_info;
      if (reset) begin
         foreach (shadow_regs[i]) shadow_regs[i] = '0;
         pending_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response transfer with nothing expected: status %0d we %0b",
                        $time, rsp_status, rsp_write_enable);
               $display("%0t: unexpected transfer also carried rd %0d value %h",
                        $time, rsp_dest_index, rsp_write_value);
               mismatch_count++;
            end else begin
               exp_info = pending_results.pop_front();
               if (rsp_status !== exp_info.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, exp_info.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_write_enable !== exp_info.write_enable) begin
                  $display("%0t: write_enable expected %0b actual %0b",
                           $time, exp_info.write_enable, rsp_write_enable);
                  mismatch_count++;
               end
               if (rsp_dest_index !== exp_info.dest_index) begin
                  $display("%0t: dest_index expected %0d actual %0d",
                           $time, exp_info.dest_index, rsp_dest_index);
                  mismatch_count++;
               end
               if (rsp_write_value !== exp_info.write_value) begin
                  $display("%0t: write_value expected %h actual %h",
                           $time, exp_info.write_value, rsp_write_value);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            exp_info = predict_retire(req_instruction);
            if (exp_info.write_enable) shadow_regs[exp_info.dest_index] = exp_info.write_value;
            pending_results.push_back(exp_info);
         end
      end
      pending_count = pending_results.size();
   end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import rvalu_pkg::*;

   localparam int StallLimit = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_instruction = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_write_enable;
   logic [4:0]  rsp_dest_index;
   logic [31:0] rsp_write_value;

   int send_idle  = 0;
   int recv_stall = 0;
   int quiet_cycles = 0;
   int mismatch_count;
   int pending_count;

   always #6 clock = ~clock;

   rv32i_integer_alu_execute_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_instruction  (req_instruction),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_write_enable (rsp_write_enable),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_write_value  (rsp_write_value)
   );

   alu_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_instruction  (req_instruction),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_write_enable (rsp_write_enable),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_write_value  (rsp_write_value),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall);
   end

   // The run is abandoned if no transfer takes place on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [31:0] enc_imm(logic [11:0] imm, logic [4:0] rs1,
                                           funct3_type f3, logic [4:0] rd);
      return {imm, rs1, f3, rd, OpcImm};
   endfunction

   function automatic logic [31:0] enc_reg(logic [6:0] f7, logic [4:0] rs2,
                                           logic [4:0] rs1, funct3_type f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, OpcReg};
   endfunction

   function automatic logic [31:0] random_instr();
      logic [31:0] w;
      logic [6:0]  f7;
      funct3_type  f3;
      logic [4:0]  rd;
      w = $urandom();
      if ($urandom_range(99) < 15) return w;
      f3 = funct3_type'(w[14:12]);
      rd = ($urandom_range(9) == 0) ? 5'd0 : w[11:7];
      case ($urandom_range(9))
         0:       f7 = w[31:25];
         1, 2, 3: f7 = Funct7Alt;
         default: f7 = Funct7Zero;
      endcase
      if ($urandom_range(1) == 0) return enc_reg(f7, w[24:20], w[19:15], f3, rd);
      if (f3 == F3Sll || f3 == F3Shr) return enc_imm({f7, w[24:20]}, w[19:15], f3, rd);
      return enc_imm(w[31:20], w[19:15], f3, rd);
   endfunction

   task automatic send_instr(input logic [31:0] word);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_instruction <= word;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      int phase;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_instr(enc_imm(12'hFFF, 5'd0, F3AddSub, 5'd1));
      send_instr(enc_imm(12'h7FF, 5'd0, F3AddSub, 5'd2));
      send_instr(enc_imm(12'h800, 5'd0, F3AddSub, 5'd3));
      send_instr(enc_imm({Funct7Zero, 5'd31}, 5'd2, F3Sll, 5'd4));
      send_instr(enc_imm({Funct7Zero, 5'd31}, 5'd1, F3Shr, 5'd5));
      send_instr(enc_imm({Funct7Alt, 5'd31}, 5'd4, F3Shr, 5'd6));
      send_instr(enc_imm(12'h000, 5'd3, F3Slt, 5'd7));
      send_instr(enc_imm(12'hFFF, 5'd3, F3Sltu, 5'd8));
      send_instr(enc_imm(12'h555, 5'd1, F3Xor, 5'd9));
      send_instr(enc_imm(12'h800, 5'd2, F3Or, 5'd10));
      send_instr(enc_imm(12'h7FF, 5'd1, F3And, 5'd11));
      send_instr(enc_reg(Funct7Zero, 5'd2, 5'd1, F3AddSub, 5'd12));
      send_instr(enc_reg(Funct7Alt, 5'd2, 5'd3, F3AddSub, 5'd13));
      send_instr(enc_reg(Funct7Zero, 5'd5, 5'd1, F3Sll, 5'd14));
      send_instr(enc_reg(Funct7Zero, 5'd2, 5'd3, F3Slt, 5'd15));
      send_instr(enc_reg(Funct7Zero, 5'd2, 5'd3, F3Sltu, 5'd16));
      send_instr(enc_reg(Funct7Zero, 5'd9, 5'd1, F3Xor, 5'd17));
      send_instr(enc_reg(Funct7Zero, 5'd2, 5'd1, F3Shr, 5'd18));
      send_instr(enc_reg(Funct7Alt, 5'd2, 5'd1, F3Shr, 5'd19));
      send_instr(enc_reg(Funct7Zero, 5'd3, 5'd2, F3Or, 5'd20));
      send_instr(enc_reg(Funct7Zero, 5'd9, 5'd1, F3And, 5'd21));
      send_instr(enc_reg(Funct7Zero, 5'd2, 5'd1, F3AddSub, 5'd0));
      send_instr(enc_imm({Funct7Alt, 5'd3}, 5'd1, F3Sll, 5'd22));
      send_instr(enc_reg(7'h7F, 5'd2, 5'd1, F3Shr, 5'd23));
      send_instr(32'hFFFF_FFFF);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle = 0;  recv_stall = 0;  end
            1:       begin send_idle = 82; recv_stall = 0;  end
            2:       begin send_idle = 0;  recv_stall = 82; end
            default: begin send_idle = 18; recv_stall = 18; end
         endcase
         repeat (240) send_instr(random_instr());
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== rv32i_integer_alu_execute_unit.f =====
hdl/rvalu_pkg.sv
hdl/rv32i_integer_alu_execute_unit.sv
tb/alu_result_checker.sv
tb/tb_top.sv
